FILE: design/mta_pkg.sv
package mta_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 10;
    localparam int POS_W     = 32;
    localparam int TEX_W     = 24;
    localparam int TAN_W     = 18;
    localparam int SUM_W     = 32;
    localparam int SKIP_W    = 16;
    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 80;

    // Command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRI  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Sequencer states
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_FETCH  = 11'b000_0000_0010,
        ST_DELTA  = 11'b000_0000_0100,
        ST_MUL    = 11'b000_0000_1000,
        ST_SHIFT  = 11'b000_0001_0000,
        ST_SQUARE = 11'b000_0010_0000,
        ST_SQRT   = 11'b000_0100_0000,
        ST_DIV    = 11'b000_1000_0000,
        ST_UPDATE = 11'b001_0000_0000,
        ST_RDWAIT = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

endpackage

FILE: design/mta_ram.sv
module mta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port (old data on collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mesh_tangent_accumulator.sv
// Load word: no result; the block stays ready.
// Triangle word: fetch, delta, multiply, scale shifts, square, square-root steps, three
// restoring divisions and a read-modify-write of each corner; a degenerate one ends early,
// in the multiply or the square step. Read word: the stored tangent is normalized and sent out.
// The square root and the three restoring divisions take most of the time.
// aresetn (synchronous, active low) clears the sequencer, output valid and skip count;
// the vertex stores are not cleared and hold garbage until loaded.
module mesh_tangent_accumulator #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v, corner_a, corner_b, corner_c
    input  logic [mta_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [mta_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // vertex_id, tangent_x, tangent_y, tangent_z, skipped_triangles
    output logic [mta_pkg::M_TDATA_W-1:0] m_tdata
);

    import mta_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    // input fields
    logic [IDX_W-1:0] in_vi, in_a, in_b, in_c;
    logic [POS_W-1:0] in_px, in_py, in_pz;
    logic [TEX_W-1:0] in_tu, in_tv;
    logic             vi_ok, tri_ok, s_fire;

    assign in_vi = s_tdata[9:0];
    assign in_px = s_tdata[41:10];
    assign in_py = s_tdata[73:42];
    assign in_pz = s_tdata[105:74];
    assign in_tu = s_tdata[129:106];
    assign in_tv = s_tdata[153:130];
    assign in_a  = s_tdata[163:154];
    assign in_b  = s_tdata[173:164];
    assign in_c  = s_tdata[183:174];

    assign vi_ok  = 32'(in_vi) < MAX_VERTICES;
    assign tri_ok = (32'(in_a) < MAX_VERTICES) && (32'(in_b) < MAX_VERTICES)
                 && (32'(in_c) < MAX_VERTICES);

    state_t state_reg;
    logic [5:0] cnt_reg;
    logic [1:0] comp_reg;
    logic       rd_op_reg;
    logic [IDX_W-1:0] vi_reg, idx_a_reg, idx_b_reg, idx_c_reg;

    logic signed [TEX_W-1:0] tex_reg [3][2];
    logic signed [POS_W-1:0] pos_reg [3][3];
    logic signed [24:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [32:0] e1_reg [3];
    logic signed [32:0] e2_reg [3];

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               det_neg_reg;
    logic [59:0]        mag_reg [3];
    logic [2:0]         neg_reg;

    logic [63:0] sum_reg, res_reg, bit_reg;
    logic [47:0] rem_reg;
    logic [48:0] den_reg;
    logic [16:0] q_reg;
    logic signed [TAN_W-1:0] tan_reg [3];

    logic [SKIP_W-1:0]    skip_cnt_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // RAM ports
    logic [95:0] pos_rdata, tan_rdata, tan_wdata;
    logic [47:0] tex_rdata;
    logic        ld_we, tan_we;
    logic [IDX_W-1:0] rd_idx, tan_widx, corner;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign ld_we    = s_fire && (s_tuser == CMD_LOAD) && vi_ok;

    // corner under update
    always_comb begin
        case (comp_reg)
            2'd0:    corner = idx_a_reg;
            2'd1:    corner = idx_b_reg;
            default: corner = idx_c_reg;
        endcase
    end

    // shared read address
    always_comb begin
        rd_idx = vi_reg;
        if (state_reg == ST_FETCH) begin
            case (cnt_reg[1:0])
                2'd0:    rd_idx = idx_a_reg;
                2'd1:    rd_idx = idx_b_reg;
                default: rd_idx = idx_c_reg;
            endcase
        end else if (state_reg == ST_UPDATE) begin
            rd_idx = corner;
        end
    end

    // saturating accumulate of the new tangent
    logic signed [32:0] upd_sum [3];
    logic [95:0]        upd_word;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            upd_sum[i] = 33'($signed(tan_rdata[32*i +: 32])) + 33'(tan_reg[i]);
            if (upd_sum[i][32] != upd_sum[i][31]) begin
                upd_word[32*i +: 32] = upd_sum[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                upd_word[32*i +: 32] = upd_sum[i][31:0];
            end
        end
    end

    assign tan_we    = ld_we || ((state_reg == ST_UPDATE) && cnt_reg[0]);
    assign tan_widx  = ld_we ? in_vi : corner;
    assign tan_wdata = ld_we ? 96'd0 : upd_word;

    mta_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .aclk  (aclk),
        .we    (ld_we),
        .waddr (AW'(in_vi)),
        .wdata ({in_pz, in_py, in_px}),
        .raddr (AW'(rd_idx)),
        .rdata (pos_rdata)
    );

    mta_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_tex_ram (
        .aclk  (aclk),
        .we    (ld_we),
        .waddr (AW'(in_vi)),
        .wdata ({in_tv, in_tu}),
        .raddr (AW'(rd_idx)),
        .rdata (tex_rdata)
    );

    mta_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_tan_ram (
        .aclk  (aclk),
        .we    (tan_we),
        .waddr (AW'(tan_widx)),
        .wdata (tan_wdata),
        .raddr (AW'(rd_idx)),
        .rdata (tan_rdata)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL) begin
            case (cnt_reg[2:0])
                3'd0: begin mul_a = 34'(du1_reg); mul_b = 34'(dv2_reg);   end
                3'd1: begin mul_a = 34'(du2_reg); mul_b = 34'(dv1_reg);   end
                3'd2: begin mul_a = 34'(dv2_reg); mul_b = 34'(e1_reg[0]); end
                3'd3: begin mul_a = 34'(dv1_reg); mul_b = 34'(e2_reg[0]); end
                3'd4: begin mul_a = 34'(dv2_reg); mul_b = 34'(e1_reg[1]); end
                3'd5: begin mul_a = 34'(dv1_reg); mul_b = 34'(e2_reg[1]); end
                3'd6: begin mul_a = 34'(dv2_reg); mul_b = 34'(e1_reg[2]); end
                default: begin mul_a = 34'(dv1_reg); mul_b = 34'(e2_reg[2]); end
            endcase
        end else if ((state_reg == ST_SQUARE) && (cnt_reg[1:0] != 2'd3)) begin
            mul_a = $signed({4'b0, mag_reg[cnt_reg[1:0]][29:0]});
            mul_b = mul_a;
        end
    end

    // datapath helpers
    logic signed [63:0] diff_w, diff_mag;
    logic [1:0]  rj;
    logic        big;
    logic [63:0] sum_w, tsq;
    logic        ge;
    logic [16:0] qf;
    logic signed [TAN_W-1:0] tan_w;
    logic signed [SUM_W-1:0] rd_sum [3];
    logic [59:0] rd_mag [3];

    assign diff_w   = acc_reg - $signed(prod_reg[63:0]);
    assign diff_mag = diff_w[63] ? -diff_w : diff_w;
    assign rj       = 2'(cnt_reg[3:1] - 3'd2);
    assign big      = (|mag_reg[0][59:30]) || (|mag_reg[1][59:30]) || (|mag_reg[2][59:30]);
    assign sum_w    = sum_reg + prod_reg[63:0];
    assign tsq      = res_reg + bit_reg;
    assign ge       = {1'b0, rem_reg} >= den_reg;
    assign qf       = {q_reg[15:0], ge};
    assign tan_w    = neg_reg[comp_reg] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rd_sum[i] = $signed(tan_rdata[32*i +: 32]);
            rd_mag[i] = rd_sum[i][31] ? 60'(-33'(rd_sum[i])) : 60'(rd_sum[i]);
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            skip_cnt_reg <= '0;
            cnt_reg      <= '0;
            comp_reg     <= '0;
        end else begin
            // ST_OUT refills the register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        vi_reg    <= in_vi;
                        idx_a_reg <= in_a;
                        idx_b_reg <= in_b;
                        idx_c_reg <= in_c;
                        rd_op_reg <= (s_tuser == CMD_READ);
                        cnt_reg   <= '0;
                        comp_reg  <= '0;
                        case (s_tuser)
                            CMD_TRI: begin
                                if (tri_ok) begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            CMD_READ: begin
                                if (vi_ok) begin
                                    state_reg <= ST_RDWAIT;
                                end else begin
                                    for (int i = 0; i < 3; i++) tan_reg[i] <= '0;
                                    state_reg <= ST_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // read the three corners, one per cycle
                ST_FETCH: begin
                    if (cnt_reg[1:0] != 2'd0) begin
                        tex_reg[cnt_reg[1:0]-2'd1][0] <= tex_rdata[23:0];
                        tex_reg[cnt_reg[1:0]-2'd1][1] <= tex_rdata[47:24];
                        for (int i = 0; i < 3; i++) begin
                            pos_reg[cnt_reg[1:0]-2'd1][i] <= pos_rdata[32*i +: 32];
                        end
                    end
                    if (cnt_reg[1:0] == 2'd3) begin
                        state_reg <= ST_DELTA;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                // edge and UV deltas
                ST_DELTA: begin
                    du1_reg <= 25'(tex_reg[1][0]) - 25'(tex_reg[0][0]);
                    dv1_reg <= 25'(tex_reg[1][1]) - 25'(tex_reg[0][1]);
                    du2_reg <= 25'(tex_reg[2][0]) - 25'(tex_reg[0][0]);
                    dv2_reg <= 25'(tex_reg[2][1]) - 25'(tex_reg[0][1]);
                    for (int i = 0; i < 3; i++) begin
                        e1_reg[i] <= 33'(pos_reg[1][i]) - 33'(pos_reg[0][i]);
                        e2_reg[i] <= 33'(pos_reg[2][i]) - 33'(pos_reg[0][i]);
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                // products issued at step n are consumed at step n+1
                ST_MUL: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    case (cnt_reg) inside
                        6'd1, 6'd3, 6'd5, 6'd7: acc_reg <= $signed(prod_reg[63:0]);
                        6'd2: begin
                            if (diff_w == 64'sd0) begin
                                if (skip_cnt_reg != {SKIP_W{1'b1}}) begin
                                    skip_cnt_reg <= skip_cnt_reg + 16'd1;
                                end
                                state_reg <= ST_IDLE;
                            end
                            det_neg_reg <= diff_w[63];
                        end
                        6'd4, 6'd6, 6'd8: begin
                            mag_reg[rj] <= diff_mag[59:0];
                            neg_reg[rj] <= diff_w[63] ^ det_neg_reg;
                            if (cnt_reg == 6'd8) begin
                                state_reg <= ST_SHIFT;
                            end
                        end
                        default: ;
                    endcase
                end
                // scale until every magnitude is below 2^30
                ST_SHIFT: begin
                    if (big) begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end else begin
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_SQUARE;
                    end
                end
                // sum of squares
                ST_SQUARE: begin
                    if (cnt_reg != 6'd0) begin
                        sum_reg <= sum_w;
                    end
                    if (cnt_reg == 6'd3) begin
                        cnt_reg <= '0;
                        if (sum_w == 64'd0) begin
                            for (int i = 0; i < 3; i++) tan_reg[i] <= '0;
                            state_reg <= rd_op_reg ? ST_OUT : ST_IDLE;
                        end else begin
                            res_reg   <= '0;
                            bit_reg   <= 64'd1 << 62;
                            state_reg <= ST_SQRT;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                // integer square root, one result bit per cycle
                ST_SQRT: begin
                    if (sum_reg >= tsq) begin
                        sum_reg <= sum_reg - tsq;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == 6'd31) begin
                        cnt_reg   <= '0;
                        comp_reg  <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                // rounded mag*2^16/n, restoring division per component
                ST_DIV: begin
                    if (cnt_reg == 6'd0) begin
                        rem_reg <= {1'b0, mag_reg[comp_reg][29:0], 17'b0}
                                 + 48'(res_reg[31:0]);
                        den_reg <= 49'({res_reg[31:0], 1'b0}) << 16;
                        q_reg   <= '0;
                        cnt_reg <= 6'd1;
                    end else begin
                        if (ge) begin
                            rem_reg <= rem_reg - den_reg[47:0];
                        end
                        den_reg <= den_reg >> 1;
                        q_reg   <= qf;
                        if (cnt_reg == 6'd17) begin
                            tan_reg[comp_reg] <= tan_w;
                            cnt_reg <= '0;
                            if (comp_reg == 2'd2) begin
                                comp_reg  <= '0;
                                state_reg <= rd_op_reg ? ST_OUT : ST_UPDATE;
                            end else begin
                                comp_reg <= comp_reg + 2'd1;
                            end
                        end else begin
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                end
                // read, then write back each corner
                ST_UPDATE: begin
                    if (!cnt_reg[0]) begin
                        cnt_reg <= 6'd1;
                    end else begin
                        cnt_reg  <= '0;
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RDWAIT: begin
                    if (!cnt_reg[0]) begin
                        cnt_reg <= 6'd1;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= rd_mag[i];
                            neg_reg[i] <= rd_sum[i][31];
                        end
                        state_reg <= ST_SHIFT;
                    end
                end
                // hand the word to the output register once it is free
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {skip_cnt_reg, tan_reg[2], tan_reg[1], tan_reg[0],
                                         vi_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: design/mta_checker.sv
module mta_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mta_pkg::CMD_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mta_pkg::M_TDATA_W-1:0] m_tdata
);

    import mta_pkg::*;

    // a pending word is held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // a read keeps the block busy for at least the next cycle
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_READ) |=> !s_tready)
        else $error("ready right after a read");

    // after a load the block is ready again in the next cycle
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_LOAD) |=> s_tready)
        else $error("not ready after a load");

    // normalized components stay within plus or minus one
    a_tan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[27] == m_tdata[26]) || (m_tdata[25:10] == 16'd0))
                  && ((m_tdata[45] == m_tdata[44]) || (m_tdata[43:28] == 16'd0))
                  && ((m_tdata[63] == m_tdata[62]) || (m_tdata[61:46] == 16'd0)))
        else $error("tangent component out of range");

endmodule

bind mesh_tangent_accumulator mta_checker u_mta_checker (.*);
